FILE: rtl/core/dgt_pkg.sv
// ----------------------------------------------------------------------------
// dgt_pkg
// Shared types and constants of the directional gradient threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

package dgt_pkg;

  localparam int REQ_W    = 2;
  localparam int INDEX_W  = 17;
  localparam int OFFSET_W = 16;
  localparam int SAMPLE_W = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int IMG_W    = 20;
  localparam int EXT_W    = 21;
  localparam int BINS     = 256;
  localparam int QUO_W    = 8;

  localparam logic [REQ_W-1:0] REQ_LOAD_H = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_V = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PIXEL  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_R = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_C = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_ACC_PIX,
    ST_TAP_RD,
    ST_TAP_ADR,
    ST_TAP_ADD,
    ST_PK_RD,
    ST_PK_WR,
    ST_PEAK_RD,
    ST_PEAK_USE,
    ST_NRM_RD,
    ST_NRM_LOAD,
    ST_NRM_DIV,
    ST_NRM_HRD,
    ST_NRM_HWR,
    ST_THR_RD,
    ST_THR_USE
  } state_t;

  typedef struct packed {
    logic pass_init;
    logic clr_step;
    logic cnt_clr;
    logic pix_init;
    logic adv;
    logic tap_lat;
    logic tap_add;
    logic pk_ra_idx;
    logic pk_wr;
    logic pk_use;
    logic div_start;
    logic nrm_wr;
    logic hist_ra_quo;
    logic hist_inc;
    logic thr_init;
    logic thr_use;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic no_acc;
    logic idx_out;
    logic taps_zero;
    logic tap_last;
    logic adv_last;
    logic cnt_ge_total;
    logic cnt_ge_bins;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/dgt_div.sv
// ----------------------------------------------------------------------------
// dgt_div
// Restoring divider, one quotient bit per cycle, for quotients below 256.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_div #(
  parameter int DW = 21,
  parameter int VW = 13
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [DW-1:0]           dividend,
  input  wire logic [VW-1:0]           divisor,
  output logic [dgt_pkg::QUO_W-1:0]    quotient,
  output logic                         done
);

  logic [DW-1:0] rem;
  logic [DW-1:0] dsh;
  logic [3:0]    step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (start) begin
      step <= 4'(dgt_pkg::QUO_W);
    end else if (step != '0) begin
      step <= step - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= DW'(divisor) << (dgt_pkg::QUO_W - 1);
      quotient <= '0;
    end else if (step != '0) begin
      if (rem >= dsh) begin
        rem      <= rem - dsh;
        quotient <= {quotient[dgt_pkg::QUO_W-2:0], 1'b1};
      end else begin
        quotient <= {quotient[dgt_pkg::QUO_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  assign done = (step == '0);

endmodule

`default_nettype wire

FILE: rtl/core/dgt_datapath.sv
// ----------------------------------------------------------------------------
// dgt_datapath
// Stores, loop counters, accumulators, histogram and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_datapath #(
  parameter int MAX_PIXELS = 131072,
  parameter int MAX_ANGLES = 8,
  parameter int MAX_TAPS   = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dgt_pkg::cmd_t                  cmd,
  output dgt_pkg::status_t                    st,
  input  wire logic                           accept,
  input  wire logic [dgt_pkg::REQ_W-1:0]      req_type,
  input  wire logic [dgt_pkg::INDEX_W-1:0]    item_index,
  input  wire logic [dgt_pkg::OFFSET_W-1:0]   offset_value,
  input  wire logic [dgt_pkg::SAMPLE_W-1:0]   gy_sample,
  input  wire logic [dgt_pkg::SAMPLE_W-1:0]   gx_sample,
  input  wire logic [9:0]                     image_rows,
  input  wire logic [9:0]                     image_cols,
  input  wire logic [3:0]                     angle_count,
  input  wire logic [5:0]                     kernel_taps,
  input  wire logic [7:0]                     margin_rows,
  input  wire logic [7:0]                     margin_cols,
  input  wire logic [15:0]                    threshold_fraction,
  output logic                                done,
  output logic [7:0]                          binary_value,
  output logic [7:0]                          normalized_value,
  output logic [7:0]                          threshold_level,
  output logic                                result_ready
);

  localparam int PW = $clog2(MAX_PIXELS);
  localparam int TD = MAX_ANGLES * MAX_TAPS;
  localparam int TW = (TD > 1) ? $clog2(TD) : 1;
  localparam int SW = $clog2(MAX_TAPS * 255 + 1);
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int NW = (CW > 9) ? CW : 9;
  localparam int DW = SW + dgt_pkg::QUO_W;
  localparam int EW = dgt_pkg::EXT_W;

  logic [7:0]    gy_mem   [MAX_PIXELS];
  logic [7:0]    gx_mem   [MAX_PIXELS];
  logic [SW-1:0] pk_mem   [MAX_PIXELS];
  logic [7:0]    norm_mem [MAX_PIXELS];
  logic [15:0]   h_tab    [TD];
  logic [15:0]   v_tab    [TD];
  logic [CW-1:0] hist     [dgt_pkg::BINS];

  logic [dgt_pkg::IMG_W-1:0] prod, mr_base, line_base, idx;
  logic [CW-1:0]  total, target, cum, cum_sum;
  logic [6:0]     ang_lim, tap_lim, a, k;
  logic [10:0]    x_end, y_end;
  logic [9:0]     x, y;
  logic [TW-1:0]  t, abase;
  logic [NW-1:0]  cnt;
  logic [15:0]    h_q, v_q;
  logic [7:0]     gy_q, gx_q, norm_q;
  logic [SW-1:0]  sh, sv, pk_q, gpeak, pk_new;
  logic [CW-1:0]  hist_q;
  logic [21:0]    ph, pv;
  logic           ok_h, ok_v, ok_h_now, ok_v_now;
  logic [PW-1:0]  pk_ra, pk_wa;
  logic [7:0]     hist_ra, thr, quo, res_thr;
  logic           found, done_flag, res_in, res_rdy;
  logic           pk_we, hist_we;
  logic [SW-1:0]  pk_wd;
  logic [7:0]     hist_wa;
  logic [CW-1:0]  hist_wd;
  logic           div_done;
  logic [DW-1:0]  dividend;
  logic           is_read, is_pixel, tab_in, pix_in;

  assign prod    = 20'(image_rows) * 20'(image_cols);
  assign total   = (21'(prod) >= 21'(MAX_PIXELS)) ? CW'(MAX_PIXELS) : CW'(prod);
  assign mr_base = 20'(margin_rows) * 20'(image_cols);
  assign ang_lim = (7'(angle_count) > 7'(MAX_ANGLES)) ? 7'(MAX_ANGLES) : 7'(angle_count);
  assign tap_lim = (7'(kernel_taps) > 7'(MAX_TAPS)) ? 7'(MAX_TAPS) : 7'(kernel_taps);
  assign x_end   = 11'(image_cols) - 11'(margin_cols);
  assign y_end   = 11'(image_rows) - 11'(margin_rows);
  assign idx     = line_base + 20'(x);
  assign target  = CW'(((CW + 16)'(total) * (CW + 16)'(threshold_fraction)) >> 16);

  assign ph = $signed({2'b00, idx}) + $signed({{6{h_q[15]}}, h_q});
  assign pv = $signed({2'b00, idx}) + $signed({{6{v_q[15]}}, v_q});
  assign ok_h_now = !ph[21] && (ph[20:0] < EW'(total));
  assign ok_v_now = !pv[21] && (pv[20:0] < EW'(total));

  assign is_read  = accept && (req_type == dgt_pkg::REQ_READ);
  assign is_pixel = accept && (req_type == dgt_pkg::REQ_PIXEL);
  assign tab_in   = EW'(item_index) < EW'(TD);
  assign pix_in   = EW'(item_index) < EW'(MAX_PIXELS);

  assign st.clr_done     = (cnt >= NW'(total)) && (cnt >= NW'(dgt_pkg::BINS));
  assign st.no_acc       = !(11'(image_rows) > {2'b00, margin_rows, 1'b0}) ||
                           !(11'(image_cols) > {2'b00, margin_cols, 1'b0}) ||
                           (ang_lim == '0);
  assign st.idx_out      = EW'(idx) >= EW'(total);
  assign st.taps_zero    = (tap_lim == '0);
  assign st.tap_last     = (8'(k) + 8'd1) >= 8'(tap_lim);
  assign st.adv_last     = ((11'(x) + 11'd1) >= x_end) && ((11'(y) + 11'd1) >= y_end) &&
                           ((8'(a) + 8'd1) >= 8'(ang_lim));
  assign st.cnt_ge_total = cnt >= NW'(total);
  assign st.cnt_ge_bins  = cnt >= NW'(dgt_pkg::BINS);
  assign st.div_done     = div_done;

  // offset tables
  always_ff @(posedge clk) begin
    if (accept && (req_type == dgt_pkg::REQ_LOAD_H) && tab_in) begin
      h_tab[TW'(item_index)] <= offset_value;
    end
    h_q <= h_tab[t];
  end

  always_ff @(posedge clk) begin
    if (accept && (req_type == dgt_pkg::REQ_LOAD_V) && tab_in) begin
      v_tab[TW'(item_index)] <= offset_value;
    end
    v_q <= v_tab[t];
  end

  // gradient stores
  always_ff @(posedge clk) begin
    if (is_pixel && pix_in) begin
      gy_mem[PW'(item_index)] <= gy_sample;
    end
    gy_q <= gy_mem[PW'(ph[20:0])];
  end

  always_ff @(posedge clk) begin
    if (is_pixel && pix_in) begin
      gx_mem[PW'(item_index)] <= gx_sample;
    end
    gx_q <= gx_mem[PW'(pv[20:0])];
  end

  // peak store
  always_comb begin
    pk_new = pk_q;
    if (sh > pk_new) pk_new = sh;
    if (sv > pk_new) pk_new = sv;
    pk_ra = cmd.pk_ra_idx ? PW'(idx) : PW'(cnt);
    pk_we = 1'b0;
    pk_wa = PW'(cnt);
    pk_wd = '0;
    if (cmd.clr_step && (cnt < NW'(total))) begin
      pk_we = 1'b1;
    end else if (cmd.pk_wr) begin
      pk_we = 1'b1;
      pk_wa = PW'(idx);
      pk_wd = pk_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_we) begin
      pk_mem[pk_wa] <= pk_wd;
    end
    pk_q <= pk_mem[pk_ra];
  end

  // normalized store
  always_ff @(posedge clk) begin
    if (cmd.nrm_wr) begin
      norm_mem[PW'(cnt)] <= quo;
    end
    norm_q <= norm_mem[PW'(item_index)];
  end

  // histogram
  always_comb begin
    hist_ra = cmd.hist_ra_quo ? quo : cnt[7:0];
    hist_we = 1'b0;
    hist_wa = cnt[7:0];
    hist_wd = '0;
    if (cmd.clr_step && (cnt < NW'(dgt_pkg::BINS))) begin
      hist_we = 1'b1;
    end else if (cmd.hist_inc) begin
      hist_we = 1'b1;
      hist_wa = quo;
      hist_wd = hist_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[hist_wa] <= hist_wd;
    end
    hist_q <= hist[hist_ra];
  end

  assign dividend = {pk_q, 8'b0} - DW'(pk_q);

  dgt_div #(
    .DW(DW),
    .VW(SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (gpeak),
    .quotient (quo),
    .done     (div_done)
  );

  // loop counters and accumulators
  always_ff @(posedge clk) begin
    if (cmd.pass_init) begin
      a         <= '0;
      abase     <= '0;
      y         <= 10'(margin_rows);
      x         <= 10'(margin_cols);
      line_base <= mr_base;
    end else if (cmd.adv) begin
      if ((11'(x) + 11'd1) < x_end) begin
        x <= x + 10'd1;
      end else begin
        x <= 10'(margin_cols);
        if ((11'(y) + 11'd1) < y_end) begin
          y         <= y + 10'd1;
          line_base <= line_base + 20'(image_cols);
        end else begin
          y         <= 10'(margin_rows);
          line_base <= mr_base;
          a         <= a + 7'd1;
          abase     <= abase + TW'(tap_lim);
        end
      end
    end
    if (cmd.pix_init) begin
      sh <= '0;
      sv <= '0;
      t  <= abase;
      k  <= '0;
    end else if (cmd.tap_add) begin
      sh <= sh + (ok_h ? SW'(gy_q) : SW'(0));
      sv <= sv + (ok_v ? SW'(gx_q) : SW'(0));
      t  <= t + TW'(1);
      k  <= k + 7'd1;
    end
    if (cmd.tap_lat) begin
      ok_h <= ok_h_now;
      ok_v <= ok_v_now;
    end
    if (cmd.pass_init || cmd.cnt_clr || cmd.thr_init) begin
      cnt <= '0;
    end else if (cmd.clr_step || cmd.pk_use || cmd.hist_inc || cmd.thr_use) begin
      cnt <= cnt + NW'(1);
    end
    if (cmd.thr_init) begin
      cum   <= '0;
      found <= 1'b0;
    end else if (cmd.thr_use) begin
      cum <= cum_sum;
      if (!found && (cum_sum >= target)) begin
        found <= 1'b1;
      end
    end
  end

  assign cum_sum = cum + hist_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      gpeak     <= SW'(1);
      thr       <= 8'd255;
      done_flag <= 1'b0;
    end else begin
      if (cmd.pass_init) begin
        gpeak <= SW'(1);
      end else if (cmd.pk_use && (pk_q > gpeak)) begin
        gpeak <= pk_q;
      end
      if (cmd.thr_init) begin
        thr <= 8'd255;
      end else if (cmd.thr_use && !found && (cum_sum >= target)) begin
        thr <= cnt[7:0];
      end
      if (is_pixel) begin
        done_flag <= 1'b0;
      end else if (cmd.finish) begin
        done_flag <= 1'b1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      res_in  <= EW'(item_index) < EW'(total);
      res_thr <= thr;
      res_rdy <= done_flag;
    end
  end

  assign normalized_value = res_in ? norm_q : 8'd0;
  assign binary_value     = (normalized_value > res_thr) ? 8'd255 : 8'd0;
  assign threshold_level  = res_thr;
  assign result_ready     = res_rdy;

endmodule

`default_nettype wire

FILE: rtl/core/dgt_ctrl.sv
// ----------------------------------------------------------------------------
// dgt_ctrl
// Pass sequencer: clear, accumulate, peak search, normalize, threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire dgt_pkg::status_t  st,
  output dgt_pkg::cmd_t          cmd,
  output logic                   busy
);

  dgt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      dgt_pkg::ST_IDLE: begin
        if (go) begin
          cmd.pass_init = 1'b1;
          state_next    = dgt_pkg::ST_CLR;
        end
      end
      dgt_pkg::ST_CLR: begin
        if (st.clr_done) begin
          cmd.cnt_clr = 1'b1;
          state_next  = st.no_acc ? dgt_pkg::ST_PEAK_RD : dgt_pkg::ST_ACC_PIX;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      dgt_pkg::ST_ACC_PIX: begin
        if (st.idx_out) begin
          cmd.adv    = 1'b1;
          state_next = st.adv_last ? dgt_pkg::ST_PEAK_RD : dgt_pkg::ST_ACC_PIX;
        end else begin
          cmd.pix_init = 1'b1;
          state_next   = st.taps_zero ? dgt_pkg::ST_PK_RD : dgt_pkg::ST_TAP_RD;
        end
      end
      dgt_pkg::ST_TAP_RD: begin
        state_next = dgt_pkg::ST_TAP_ADR;
      end
      dgt_pkg::ST_TAP_ADR: begin
        cmd.tap_lat = 1'b1;
        state_next  = dgt_pkg::ST_TAP_ADD;
      end
      dgt_pkg::ST_TAP_ADD: begin
        cmd.tap_add = 1'b1;
        state_next  = st.tap_last ? dgt_pkg::ST_PK_RD : dgt_pkg::ST_TAP_RD;
      end
      dgt_pkg::ST_PK_RD: begin
        cmd.pk_ra_idx = 1'b1;
        state_next    = dgt_pkg::ST_PK_WR;
      end
      dgt_pkg::ST_PK_WR: begin
        cmd.pk_wr  = 1'b1;
        cmd.adv    = 1'b1;
        state_next = st.adv_last ? dgt_pkg::ST_PEAK_RD : dgt_pkg::ST_ACC_PIX;
      end
      dgt_pkg::ST_PEAK_RD: begin
        if (st.cnt_ge_total) begin
          cmd.cnt_clr = 1'b1;
          state_next  = dgt_pkg::ST_NRM_RD;
        end else begin
          state_next = dgt_pkg::ST_PEAK_USE;
        end
      end
      dgt_pkg::ST_PEAK_USE: begin
        cmd.pk_use = 1'b1;
        state_next = dgt_pkg::ST_PEAK_RD;
      end
      dgt_pkg::ST_NRM_RD: begin
        if (st.cnt_ge_total) begin
          cmd.thr_init = 1'b1;
          state_next   = dgt_pkg::ST_THR_RD;
        end else begin
          state_next = dgt_pkg::ST_NRM_LOAD;
        end
      end
      dgt_pkg::ST_NRM_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = dgt_pkg::ST_NRM_DIV;
      end
      dgt_pkg::ST_NRM_DIV: begin
        if (st.div_done) begin
          state_next = dgt_pkg::ST_NRM_HRD;
        end
      end
      dgt_pkg::ST_NRM_HRD: begin
        cmd.nrm_wr      = 1'b1;
        cmd.hist_ra_quo = 1'b1;
        state_next      = dgt_pkg::ST_NRM_HWR;
      end
      dgt_pkg::ST_NRM_HWR: begin
        cmd.hist_inc = 1'b1;
        state_next   = dgt_pkg::ST_NRM_RD;
      end
      dgt_pkg::ST_THR_RD: begin
        if (st.cnt_ge_bins) begin
          cmd.finish = 1'b1;
          state_next = dgt_pkg::ST_IDLE;
        end else begin
          state_next = dgt_pkg::ST_THR_USE;
        end
      end
      dgt_pkg::ST_THR_USE: begin
        cmd.thr_use = 1'b1;
        state_next  = dgt_pkg::ST_THR_RD;
      end
      default: begin
        state_next = dgt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != dgt_pkg::ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/directional_gradient_threshold.sv
// ----------------------------------------------------------------------------
// directional_gradient_threshold
// Directional line filter over gradient images with percentile binarization.
// ----------------------------------------------------------------------------
// Offset loads, pixel loads and reads are accepted back to back while busy is
// low; a read returns its transaction on the result ports in the next cycle,
// marked by done for that one cycle. A pixel marked last starts a pass and
// holds busy high until it ends. The pass runs a clearing sweep over the peak
// store and histogram, filtering of the interior pixels over every angle, one
// tap at a time through the single read port of each store, a peak search,
// normalization through the eight-step divider, and a threshold search over
// the histogram.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_gradient_threshold #(
  parameter int MAX_PIXELS = 131072,
  parameter int MAX_ANGLES = 8,
  parameter int MAX_TAPS   = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [dgt_pkg::REQ_W-1:0]        req_type,
  input  wire logic [dgt_pkg::INDEX_W-1:0]      item_index,
  input  wire logic [dgt_pkg::OFFSET_W-1:0]     offset_value,
  input  wire logic [dgt_pkg::SAMPLE_W-1:0]     gy_sample,
  input  wire logic [dgt_pkg::SAMPLE_W-1:0]     gx_sample,
  input  wire logic                             last_pixel,
  input  wire logic                             cfg_we,
  input  wire logic [dgt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dgt_pkg::CFG_W-1:0]        cfg_data,
  output logic                                  done,
  output logic [7:0]                            binary_value,
  output logic [7:0]                            normalized_value,
  output logic [7:0]                            threshold_level,
  output logic                                  result_ready
);

  logic [9:0]  image_rows, image_cols;
  logic [3:0]  angle_count;
  logic [5:0]  kernel_taps;
  logic [7:0]  margin_rows, margin_cols;
  logic [15:0] threshold_fraction;
  logic        accept, go;
  dgt_pkg::cmd_t    cmd;
  dgt_pkg::status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows         <= 10'd300;
      image_cols         <= 10'd400;
      angle_count        <= 4'd5;
      kernel_taps        <= 6'd21;
      margin_rows        <= 8'd10;
      margin_cols        <= 8'd10;
      threshold_fraction <= 16'd58982;
    end else if (cfg_we) begin
      case (cfg_index)
        dgt_pkg::CFG_ROWS:     image_rows         <= cfg_data[9:0];
        dgt_pkg::CFG_COLS:     image_cols         <= cfg_data[9:0];
        dgt_pkg::CFG_ANGLES:   angle_count        <= cfg_data[3:0];
        dgt_pkg::CFG_TAPS:     kernel_taps        <= cfg_data[5:0];
        dgt_pkg::CFG_MARGIN_R: margin_rows        <= cfg_data[7:0];
        dgt_pkg::CFG_MARGIN_C: margin_cols        <= cfg_data[7:0];
        dgt_pkg::CFG_FRACTION: threshold_fraction <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = start && !busy;
  assign go     = accept && (req_type == dgt_pkg::REQ_PIXEL) && last_pixel;

  dgt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  dgt_datapath #(
    .MAX_PIXELS(MAX_PIXELS),
    .MAX_ANGLES(MAX_ANGLES),
    .MAX_TAPS  (MAX_TAPS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .st                 (st),
    .accept             (accept),
    .req_type           (req_type),
    .item_index         (item_index),
    .offset_value       (offset_value),
    .gy_sample          (gy_sample),
    .gx_sample          (gx_sample),
    .image_rows         (image_rows),
    .image_cols         (image_cols),
    .angle_count        (angle_count),
    .kernel_taps        (kernel_taps),
    .margin_rows        (margin_rows),
    .margin_cols        (margin_cols),
    .threshold_fraction (threshold_fraction),
    .done               (done),
    .binary_value       (binary_value),
    .normalized_value   (normalized_value),
    .threshold_level    (threshold_level),
    .result_ready       (result_ready)
  );

endmodule

`default_nettype wire

FILE: rtl/core/dgt_checker.sv
// ----------------------------------------------------------------------------
// dgt_port_checks
// Port-level checks of the directional gradient threshold block.
// ----------------------------------------------------------------------------
`default_nettype none

module dgt_port_checks (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [1:0] req_type,
  input wire logic       last_pixel,
  input wire logic       done,
  input wire logic [7:0] binary_value,
  input wire logic [7:0] normalized_value,
  input wire logic [7:0] threshold_level
);

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == dgt_pkg::REQ_READ) |=> done)
    else $error("read transaction produced no result");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (req_type == dgt_pkg::REQ_READ)))
    else $error("result without a read transaction");

  a_binary_levels: assert property (@(posedge clk) disable iff (rst)
    done |-> (binary_value == 8'd0) || (binary_value == 8'd255))
    else $error("binary value is neither 0 nor 255");

  a_binary_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> ((binary_value == 8'd255) == (normalized_value > threshold_level)))
    else $error("binary value disagrees with threshold");

  a_pass_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req_type == dgt_pkg::REQ_PIXEL) && last_pixel |=> busy)
    else $error("last pixel did not start a pass");

endmodule

bind directional_gradient_threshold dgt_port_checks u_dgt_port_checks (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .req_type         (req_type),
  .last_pixel       (last_pixel),
  .done             (done),
  .binary_value     (binary_value),
  .normalized_value (normalized_value),
  .threshold_level  (threshold_level)
);

`default_nettype wire

FILE: bench/dgt_checker.sv
// ----------------------------------------------------------------------------
// dgt_checker
// Watches the command, configuration and result ports of the directional
// gradient threshold block, keeps its own copy of the tables, pixel stores and
// settings, predicts every read transaction and compares the answers.
// ----------------------------------------------------------------------------
module dgt_checker
  import dgt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [INDEX_W-1:0]    item_index,
  input  logic [OFFSET_W-1:0]   offset_value,
  input  logic [SAMPLE_W-1:0]   gy_sample,
  input  logic [SAMPLE_W-1:0]   gx_sample,
  input  logic                  last_pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  done,
  input  logic [7:0]            binary_value,
  input  logic [7:0]            normalized_value,
  input  logic [7:0]            threshold_level,
  input  logic                  result_ready,
  output int                    fail_count,
  output int                    pending,
  output int                    reads_checked,
  output int                    passes_run
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_DEPTH = 131072;
  localparam int TAB_DEPTH = 256;

  typedef struct {
    logic [7:0] bin;
    logic [7:0] nrm;
    logic [7:0] thr;
    logic       ready;
  } pixel_answer_t;

  pixel_answer_t answers[$];

  int          rows, cols, angles, taps, mrows, mcols, frac;
  logic [15:0] h_tab[TAB_DEPTH];
  logic [15:0] v_tab[TAB_DEPTH];
  logic [7:0]  gy_mem[PIX_DEPTH];
  logic [7:0]  gx_mem[PIX_DEPTH];
  logic [7:0]  nrm_mem[PIX_DEPTH];
  int          hpk[PIX_DEPTH];
  int          vpk[PIX_DEPTH];
  int          hist[256];
  int          peak;
  logic [7:0]  thr;
  logic        ready;

  function automatic int image_total();
    int n;
    n = rows * cols;
    return (n > PIX_DEPTH) ? PIX_DEPTH : n;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic sweep_image();
    int total, na, nt, idx, ph, pv, sh, sv, c, n, target, cum, t;
    bit found;
    total = image_total();
    na = (angles > 8) ? 8 : angles;
    nt = (taps > 32) ? 32 : taps;
    for (int i = 0; i < total; i++) begin
      hpk[i] = 0;
      vpk[i] = 0;
    end
    for (int b = 0; b < 256; b++) hist[b] = 0;
    if (rows > 2 * mrows && cols > 2 * mcols) begin
      for (int a = 0; a < na; a++) begin
        for (int y = mrows; y < rows - mrows; y++) begin
          for (int x = mcols; x < cols - mcols; x++) begin
            idx = y * cols + x;
            if (idx < total) begin
              sh = 0;
              sv = 0;
              for (int k = 0; k < nt; k++) begin
                t = a * nt + k;
                ph = idx + int'($signed(h_tab[t]));
                pv = idx + int'($signed(v_tab[t]));
                if (ph >= 0 && ph < total) sh += gy_mem[ph];
                if (pv >= 0 && pv < total) sv += gx_mem[pv];
              end
              if (sh > hpk[idx]) hpk[idx] = sh;
              if (sv > vpk[idx]) vpk[idx] = sv;
            end
          end
        end
      end
    end
    peak = 1;
    for (int i = 0; i < total; i++) begin
      c = (hpk[i] > vpk[i]) ? hpk[i] : vpk[i];
      hpk[i] = c;
      if (c > peak) peak = c;
    end
    for (int i = 0; i < total; i++) begin
      n = hpk[i] * 255 / peak;
      if (n > 255) n = 255;
      nrm_mem[i] = n[7:0];
      hist[n]++;
    end
    target = int'((longint'(total) * longint'(frac)) >>> 16);
    cum = 0;
    thr = 8'd255;
    found = 0;
    for (int b = 0; b < 256; b++) begin
      cum += hist[b];
      if (!found && cum >= target) begin
        thr = b[7:0];
        found = 1;
      end
    end
    ready = 1'b1;
    passes_run++;
  endtask

  always @(posedge clk) begin
    pixel_answer_t got, exp_ans;
    int n;
    if (rst) begin
      rows = 300;
      cols = 400;
      angles = 5;
      taps = 21;
      mrows = 10;
      mcols = 10;
      frac = 58982;
      peak = 1;
      thr = 8'd255;
      ready = 1'b0;
      answers.delete();
      fail_count = 0;
      reads_checked = 0;
      passes_run = 0;
    end else begin
      if (done) begin
        got = '{binary_value, normalized_value, threshold_level, result_ready};
        if (answers.size() == 0) begin
          report_mismatch("result with no read transaction waiting");
        end else begin
          exp_ans = answers.pop_front();
          reads_checked++;
          if (got.bin !== exp_ans.bin)
            report_mismatch($sformatf("binary_value %0d, want %0d", got.bin, exp_ans.bin));
          if (got.nrm !== exp_ans.nrm)
            report_mismatch($sformatf("normalized_value %0d, want %0d", got.nrm, exp_ans.nrm));
          if (got.thr !== exp_ans.thr)
            report_mismatch($sformatf("threshold_level %0d, want %0d", got.thr, exp_ans.thr));
          if (got.ready !== exp_ans.ready)
            report_mismatch($sformatf("result_ready %0b, want %0b", got.ready, exp_ans.ready));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROWS:     rows = int'(cfg_data[9:0]);
          CFG_COLS:     cols = int'(cfg_data[9:0]);
          CFG_ANGLES:   angles = int'(cfg_data[3:0]);
          CFG_TAPS:     taps = int'(cfg_data[5:0]);
          CFG_MARGIN_R: mrows = int'(cfg_data[7:0]);
          CFG_MARGIN_C: mcols = int'(cfg_data[7:0]);
          CFG_FRACTION: frac = int'(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (req_type)
          REQ_LOAD_H: if (item_index < TAB_DEPTH) h_tab[item_index] = offset_value;
          REQ_LOAD_V: if (item_index < TAB_DEPTH) v_tab[item_index] = offset_value;
          REQ_PIXEL: begin
            gy_mem[item_index] = gy_sample;
            gx_mem[item_index] = gx_sample;
            ready = 1'b0;
            if (last_pixel) sweep_image();
          end
          default: begin
            n = 0;
            if (item_index < image_total()) n = nrm_mem[item_index];
            exp_ans.bin = (n > thr) ? 8'd255 : 8'd0;
            exp_ans.nrm = n[7:0];
            exp_ans.thr = thr;
            exp_ans.ready = ready;
            answers.push_back(exp_ans);
          end
        endcase
      end
    end
    pending = answers.size();
  end

endmodule

FILE: bench/tb_directional_gradient_threshold.sv
// ----------------------------------------------------------------------------
// tb_directional_gradient_threshold
// Drives offset loads, gradient pixel loads and reads into the directional
// gradient threshold block over many small image settings, with random gaps,
// and lets the checker predict and compare every read transaction.
// ----------------------------------------------------------------------------
module tb_directional_gradient_threshold;
  timeunit 1ns;
  timeprecision 1ps;
  import dgt_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [REQ_W-1:0]     req_type = REQ_READ;
  logic [INDEX_W-1:0]   item_index = '0;
  logic [OFFSET_W-1:0]  offset_value = '0;
  logic [SAMPLE_W-1:0]  gy_sample = '0;
  logic [SAMPLE_W-1:0]  gx_sample = '0;
  logic                 last_pixel = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 done;
  logic [7:0]           binary_value, normalized_value, threshold_level;
  logic                 result_ready;
  int                   fail_count, pending, reads_checked, passes_run;

  int items_sent = 0;
  int phases = 0;
  bit h_loaded[256];
  bit v_loaded[256];

  always #5 clk = ~clk;

  directional_gradient_threshold i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .item_index(item_index), .offset_value(offset_value), .gy_sample(gy_sample),
    .gx_sample(gx_sample), .last_pixel(last_pixel), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .binary_value(binary_value), .normalized_value(normalized_value),
    .threshold_level(threshold_level), .result_ready(result_ready)
  );

  dgt_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .item_index(item_index), .offset_value(offset_value), .gy_sample(gy_sample),
    .gx_sample(gx_sample), .last_pixel(last_pixel), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .binary_value(binary_value), .normalized_value(normalized_value),
    .threshold_level(threshold_level), .result_ready(result_ready),
    .fail_count(fail_count), .pending(pending), .reads_checked(reads_checked),
    .passes_run(passes_run)
  );

  task automatic send_item(logic [REQ_W-1:0] rt, int idx, logic [15:0] off,
                           logic [7:0] gy, logic [7:0] gx, logic lst);
    int idle_pct;
    idle_pct = (items_sent < 550) ? 36 : (items_sent < 1100) ? 87 : 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_type <= rt;
    item_index <= idx[INDEX_W-1:0];
    offset_value <= off;
    gy_sample <= gy;
    gx_sample <= gx;
    last_pixel <= lst;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // hold until the block is idle and every read has answered
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_offset(int cols);
    int dy, dx;
    if ($urandom_range(0, 9) == 0) return $urandom;
    dy = $urandom_range(0, 6) - 3;
    dx = $urandom_range(0, 6) - 3;
    return 16'(dy * cols + dx);
  endfunction

  task automatic run_phase(int p);
    int rows, cols, na, nt, mr, mc, frac, total, need, reads, r;
    if (p == 1) begin
      rows = 1023; cols = 0; na = 15; nt = 63; mr = 255; mc = 255; frac = 65535;
    end else if (p == 2) begin
      rows = 0; cols = 1023; na = 0; nt = 0; mr = 0; mc = 0; frac = 0;
    end else if (p == 3) begin
      rows = 1; cols = 1; na = 8; nt = 32; mr = 0; mc = 0; frac = 32768;
    end else if (p == 4) begin
      rows = 20; cols = 10; na = 2; nt = 3; mr = 1; mc = 1; frac = $urandom_range(0, 65535);
    end else begin
      rows = $urandom_range(1, 10);
      cols = $urandom_range(1, 10);
      na = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 4);
      nt = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 6);
      mr = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 2);
      mc = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 2);
      r = $urandom_range(0, 5);
      frac = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
    end
    settle();
    configure(CFG_ROWS, rows);
    configure(CFG_COLS, cols);
    configure(CFG_ANGLES, na);
    configure(CFG_TAPS, nt);
    configure(CFG_MARGIN_R, mr);
    configure(CFG_MARGIN_C, mc);
    configure(CFG_FRACTION, frac);
    need = ((na > 8) ? 8 : na) * ((nt > 32) ? 32 : nt);
    for (int t = 0; t < need; t++) begin
      if (!h_loaded[t] || need <= 48) begin
        send_item(REQ_LOAD_H, t, pick_offset(cols), $urandom, $urandom, $urandom);
        h_loaded[t] = 1;
      end
      if (!v_loaded[t] || need <= 48) begin
        send_item(REQ_LOAD_V, t, pick_offset(cols), $urandom, $urandom, $urandom);
        v_loaded[t] = 1;
      end
    end
    total = rows * cols;
    if (total > 131072) total = 131072;
    for (int i = 0; i < total; i++)
      send_item(REQ_PIXEL, i, $urandom, $urandom, $urandom, i == total - 1);
    if (total == 0) send_item(REQ_PIXEL, $urandom, $urandom, $urandom, $urandom, 1'b1);
    reads = $urandom_range(20, 50);
    for (int j = 0; j < reads; j++) begin
      r = $urandom_range(0, 19);
      if (r < 14)
        send_item(REQ_READ, (total > 0 && r < 11) ? $urandom_range(0, total - 1) : $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      else if (r < 16)
        send_item(REQ_PIXEL, $urandom, $urandom, $urandom, $urandom, 1'b0);
      else if (r < 18)
        send_item(r == 16 ? REQ_LOAD_H : REQ_LOAD_V, $urandom_range(256, 131071),
                  $urandom, $urandom, $urandom, $urandom);
      else
        send_item(REQ_PIXEL, (total > 0) ? $urandom_range(0, total - 1) : $urandom,
                  $urandom, $urandom, $urandom, 1'b1);
    end
    phases++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset state: only reads outside the default image are legal here
    send_item(REQ_READ, 131071, 16'h0000, 8'h00, 8'h00, 1'b1);
    send_item(REQ_READ, 120000, 16'hFFFF, 8'hFF, 8'hFF, 1'b0);
    send_item(REQ_LOAD_H, 256, 16'h8000, 8'hFF, 8'h00, 1'b1);
    send_item(REQ_LOAD_V, 131071, 16'h7FFF, 8'h00, 8'hFF, 1'b0);
    send_item(REQ_LOAD_H, 0, 16'h8000, 8'h00, 8'h00, 1'b0);
    send_item(REQ_LOAD_V, 255, 16'h7FFF, 8'hFF, 8'hFF, 1'b1);
    send_item(REQ_PIXEL, 131071, 16'hFFFF, 8'hFF, 8'h00, 1'b0);
    send_item(REQ_PIXEL, 120001, 16'h0000, 8'h00, 8'hFF, 1'b0);
    send_item(REQ_READ, 131071, 16'h5555, 8'hAA, 8'h55, 1'b1);
    for (int p = 1; items_sent < 1650; p++) run_phase(p);
    settle();
    repeat (20) @(posedge clk);
    $display("Covered %0d image settings, %0d filter passes, %0d transactions sent,",
             phases, passes_run, items_sent);
    $display("and %0d read results compared field by field.", reads_checked);
    if (fail_count == 0)
      $display("directional_gradient_threshold verification clean");
    else
      $display("directional_gradient_threshold verification failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("directional_gradient_threshold verification failed");
    $finish;
  end

endmodule
